FILE: rtl/joystick_deadzone_calibrate_top_macros.svh
// assertion helpers for the joystick calibrator top
`ifndef JOYSTICK_DEADZONE_CALIBRATE_TOP_MACROS_SVH
`define JOYSTICK_DEADZONE_CALIBRATE_TOP_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define JDC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define JDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/jdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jdc_pkg;

   // sample and calibration width
   localparam int DATA_W = 10;
   // output axis width
   localparam int OUT_W = 8;
   // quotient bits resolved per divider stage
   localparam int DIV_BPS = 4;

   // register map, one register every four bytes
   typedef enum logic [2:0] {
      REG_ENABLE   = 3'd0,
      REG_DEADZONE = 3'd1,
      REG_X_MIN    = 3'd2,
      REG_X_MID    = 3'd3,
      REG_X_MAX    = 3'd4,
      REG_Y_MIN    = 3'd5,
      REG_Y_MID    = 3'd6,
      REG_Y_MAX    = 3'd7
   } reg_index_type;

   // calibration registers
   typedef struct packed {
      logic              enable;
      logic [DATA_W-1:0] dz_radius;
      logic [DATA_W-1:0] x_min;
      logic [DATA_W-1:0] x_mid;
      logic [DATA_W-1:0] x_max;
      logic [DATA_W-1:0] y_min;
      logic [DATA_W-1:0] y_mid;
      logic [DATA_W-1:0] y_max;
   } cfg_type;

   // reset values
   localparam logic              RST_ENABLE   = 1'b1;
   localparam logic [DATA_W-1:0] RST_DEADZONE = 10'd32;
   localparam logic [DATA_W-1:0] RST_MIN      = 10'd0;
   localparam logic [DATA_W-1:0] RST_MID      = 10'd512;
   localparam logic [DATA_W-1:0] RST_MAX      = 10'd1023;

   // per-axis sign and special-case flags riding along the divider
   typedef struct packed {
      logic neg;    // quotient sign
      logic dzero;  // divisor is zero, saturate
      logic nneg;   // numerator negative
      logic nzero;  // numerator zero
   } axis_side_type;

endpackage

`default_nettype wire

FILE: rtl/jdc_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module jdc_prep #(
   parameter int FULL_SCALE = 127,
   parameter int NW = 17
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [jdc_pkg::DATA_W-1:0] raw_x,
   input  wire logic [jdc_pkg::DATA_W-1:0] raw_y,
   input  wire jdc_pkg::cfg_type           cfg,
   output logic                            out_valid,
   output logic                            out_centred,
   output logic [NW-1:0]                   num_x,
   output logic [NW-1:0]                   num_y,
   output logic [jdc_pkg::DATA_W-1:0]      den_x,
   output logic [jdc_pkg::DATA_W-1:0]      den_y,
   output jdc_pkg::axis_side_type          side_x,
   output jdc_pkg::axis_side_type          side_y
);
   import jdc_pkg::*;

   localparam int FW = $clog2(FULL_SCALE + 1);
   localparam int PW = DATA_W + FW + 2;
   localparam int DW1 = DATA_W + 1;
   localparam logic signed [FW:0] FS_S = (FW + 1)'(FULL_SCALE);

   // lane 0 is x, lane 1 is y
   logic [DATA_W-1:0]          raw   [2];
   logic [DATA_W-1:0]          lo    [2];
   logic [DATA_W-1:0]          mid   [2];
   logic [DATA_W-1:0]          hi    [2];

   // stage a: offsets, squares, scaled numerators, spans
   logic signed [DW1-1:0]      d     [2];
   logic signed [2*DW1-1:0]    sqf   [2];
   logic signed [PW-1:0]       prodf [2];
   logic [2*DATA_W-1:0]        sq_in    [2];
   logic [2*DATA_W-1:0]        sq_ff    [2];
   logic signed [NW:0]         num_in   [2];
   logic signed [NW:0]         num_ff   [2];
   logic signed [DW1-1:0]      den1_in  [2];
   logic signed [DW1-1:0]      den1_ff  [2];
   logic signed [DW1-1:0]      den2_in  [2];
   logic signed [DW1-1:0]      den2_ff  [2];
   logic [2*DATA_W-1:0]        dz2_in, dz2_ff;
   logic                       en_ff;
   logic                       va_ff;

   // stage b: deadzone test, divisor choice, magnitudes
   logic [2*DATA_W:0]          len2;
   logic                       centred_in, centred_ff;
   logic [NW:0]                nneg_ext  [2];
   logic                       nneg      [2];
   logic                       nzero     [2];
   logic [NW-1:0]              nmag      [2];
   logic [DATA_W-1:0]          d1mag     [2];
   logic                       pos1      [2];
   logic signed [DW1-1:0]      dsel      [2];
   logic [DW1-1:0]             dsel_abs  [2];
   logic [NW-1:0]              nmag_ff   [2];
   logic [DATA_W-1:0]          dmag_in   [2];
   logic [DATA_W-1:0]          dmag_ff   [2];
   axis_side_type              side_in   [2];
   axis_side_type              side_ff   [2];
   logic                       vb_ff;

   // x runs with min and max swapped, which inverts it
   assign raw[0] = raw_x;
   assign raw[1] = raw_y;
   assign lo[0]  = cfg.x_max;
   assign mid[0] = cfg.x_mid;
   assign hi[0]  = cfg.x_min;
   assign lo[1]  = cfg.y_min;
   assign mid[1] = cfg.y_mid;
   assign hi[1]  = cfg.y_max;

   // stage a logic
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         d[l]       = $signed({1'b0, raw[l]}) - $signed({1'b0, mid[l]});
         sqf[l]     = d[l] * d[l];
         sq_in[l]   = sqf[l][2*DATA_W-1:0];
         prodf[l]   = d[l] * FS_S;
         num_in[l]  = prodf[l][NW:0];
         den1_in[l] = $signed({1'b0, mid[l]}) - $signed({1'b0, lo[l]});
         den2_in[l] = $signed({1'b0, hi[l]}) - $signed({1'b0, mid[l]});
      end
      dz2_in = cfg.dz_radius * cfg.dz_radius;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      for (int l = 0; l < 2; l++) begin
         sq_ff[l]   <= sq_in[l];
         num_ff[l]  <= num_in[l];
         den1_ff[l] <= den1_in[l];
         den2_ff[l] <= den2_in[l];
      end
      dz2_ff <= dz2_in;
      en_ff  <= cfg.enable;
   end

   // stage b logic
   always_comb begin
      len2       = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      centred_in = !en_ff || (len2 < {1'b0, dz2_ff});
      for (int l = 0; l < 2; l++) begin
         nneg[l]     = num_ff[l][NW];
         nzero[l]    = (num_ff[l] == '0);
         nneg_ext[l] = -num_ff[l];
         nmag[l]     = nneg[l] ? nneg_ext[l][NW-1:0] : num_ff[l][NW-1:0];
         d1mag[l]    = den1_ff[l][DW1-1] ? DATA_W'(-den1_ff[l]) : DATA_W'(den1_ff[l]);
         // first quotient positive: take the high-side span instead
         if (den1_ff[l] == '0) begin
            pos1[l] = !nneg[l] && !nzero[l];
         end else begin
            pos1[l] = !nzero[l] && (nneg[l] == den1_ff[l][DW1-1])
                      && (nmag[l] >= NW'(d1mag[l]));
         end
         dsel[l]           = pos1[l] ? den2_ff[l] : den1_ff[l];
         dsel_abs[l]       = dsel[l][DW1-1] ? DW1'(-dsel[l]) : DW1'(dsel[l]);
         dmag_in[l]        = dsel_abs[l][DATA_W-1:0];
         side_in[l].neg    = nneg[l] ^ dsel[l][DW1-1];
         side_in[l].dzero  = (dsel[l] == '0);
         side_in[l].nneg   = nneg[l];
         side_in[l].nzero  = nzero[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      centred_ff <= centred_in;
      for (int l = 0; l < 2; l++) begin
         nmag_ff[l] <= nmag[l];
         dmag_ff[l] <= dmag_in[l];
         side_ff[l] <= side_in[l];
      end
   end

   assign out_valid   = vb_ff;
   assign out_centred = centred_ff;
   assign num_x       = nmag_ff[0];
   assign num_y       = nmag_ff[1];
   assign den_x       = dmag_ff[0];
   assign den_y       = dmag_ff[1];
   assign side_x      = side_ff[0];
   assign side_y      = side_ff[1];

endmodule

`default_nettype wire

FILE: rtl/jdc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// pipelined restoring divider, unsigned magnitudes, DIV_BPS quotient bits a stage
module jdc_div #(
   parameter int NW = 17,
   parameter int SBW = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [NW-1:0]              num,
   input  wire logic [jdc_pkg::DATA_W-1:0] den,
   input  wire logic [SBW-1:0]             side_in,
   output logic                            out_valid,
   output logic [NW-1:0]                   quo,
   output logic [SBW-1:0]                  side_out
);
   import jdc_pkg::*;

   localparam int NS = (NW + DIV_BPS - 1) / DIV_BPS;

   logic [NW-1:0]     q_ff   [NS];
   logic [NW-1:0]     q_in   [NS];
   logic [DATA_W-1:0] r_ff   [NS];
   logic [DATA_W-1:0] r_in   [NS];
   logic [DATA_W-1:0] d_ff   [NS];
   logic [DATA_W-1:0] d_src  [NS];
   logic [SBW-1:0]    s_ff   [NS];
   logic [SBW-1:0]    s_src  [NS];
   logic              v_ff   [NS];
   logic              v_src  [NS];
   logic [NW-1:0]     q_w;
   logic [DATA_W-1:0] r_w;
   logic [DATA_W:0]   t_w;

   // numerator bits shift out the top while quotient bits shift in below
   always_comb begin
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            q_w      = num;
            r_w      = '0;
            d_src[s] = den;
            s_src[s] = side_in;
            v_src[s] = in_valid;
         end else begin
            q_w      = q_ff[s-1];
            r_w      = r_ff[s-1];
            d_src[s] = d_ff[s-1];
            s_src[s] = s_ff[s-1];
            v_src[s] = v_ff[s-1];
         end
         for (int j = 0; j < DIV_BPS; j++) begin
            t_w = {r_w, q_w[NW-1]};
            if (s * DIV_BPS + j < NW) begin
               q_w = {q_w[NW-2:0], 1'b0};
               if (t_w >= {1'b0, d_src[s]}) begin
                  r_w    = DATA_W'(t_w - {1'b0, d_src[s]});
                  q_w[0] = 1'b1;
               end else begin
                  r_w = t_w[DATA_W-1:0];
               end
            end
         end
         q_in[s] = q_w;
         r_in[s] = r_w;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_src[s];
         end
         q_ff[s] <= q_in[s];
         r_ff[s] <= r_in[s];
         d_ff[s] <= d_src[s];
         s_ff[s] <= s_src[s];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign quo       = q_ff[NS-1];
   assign side_out  = s_ff[NS-1];

endmodule

`default_nettype wire

FILE: rtl/jdc_post.sv
`timescale 1ns / 1ps
`default_nettype none

module jdc_post #(
   parameter int FULL_SCALE = 127,
   parameter int NW = 17
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic                        centred,
   input  wire logic [NW-1:0]               quo_x,
   input  wire logic [NW-1:0]               quo_y,
   input  wire jdc_pkg::axis_side_type      side_x,
   input  wire jdc_pkg::axis_side_type      side_y,
   output logic                             rsp_valid,
   output logic signed [jdc_pkg::OUT_W-1:0] rsp_axis_x,
   output logic signed [jdc_pkg::OUT_W-1:0] rsp_axis_y,
   output logic                             rsp_centred
);
   import jdc_pkg::*;

   localparam int FW = $clog2(FULL_SCALE + 1);
   localparam int VW = (FW + 1 > OUT_W) ? FW + 1 : OUT_W;
   localparam logic [FW-1:0] FS_U = FW'(FULL_SCALE);

   logic [NW-1:0]          q    [2];
   axis_side_type          sd   [2];
   logic [FW-1:0]          mag  [2];
   logic                   sgn  [2];
   logic signed [VW-1:0]   v    [2];
   logic [OUT_W-1:0]       ax_in [2];
   logic                   valid_ff;
   logic [OUT_W-1:0]       ax_ff [2];
   logic                   centred_ff;

   assign q[0]  = quo_x;
   assign q[1]  = quo_y;
   assign sd[0] = side_x;
   assign sd[1] = side_y;

   // zero-span saturation, clamp, sign, then zero if centred and wrap to the output width
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (sd[l].dzero) begin
            mag[l] = sd[l].nzero ? '0 : FS_U;
            sgn[l] = sd[l].nneg;
         end else begin
            mag[l] = (q[l] >= NW'(FULL_SCALE)) ? FS_U : q[l][FW-1:0];
            sgn[l] = sd[l].neg;
         end
         v[l]     = sgn[l] ? -$signed(VW'(mag[l])) : $signed(VW'(mag[l]));
         ax_in[l] = centred ? '0 : v[l][OUT_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      ax_ff[0]   <= ax_in[0];
      ax_ff[1]   <= ax_in[1];
      centred_ff <= centred;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_axis_x  = ax_ff[0];
   assign rsp_axis_y  = ax_ff[1];
   assign rsp_centred = centred_ff;

endmodule

`default_nettype wire

FILE: rtl/joystick_deadzone_calibrate_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Radial deadzone and calibration for a two-axis analog joystick.
// Input: a word (req_raw_x, req_raw_y) is taken at a clock edge with start high
// and busy low. busy is low whenever reset is low, so a word may come every cycle.
// Output: each word gives one result on rsp_axis_x, rsp_axis_y, rsp_centred,
// shown for exactly one cycle with rsp_valid high. The receiver cannot stall;
// results leave in input order.
// Pipeline: the prep stages for offset, square and scale, NS divider stages at four
// quotient bits each, where NS = ceil(NW / 4) and NW = clog2(1023 * FULL_SCALE + 1),
// and one result register.
// Throughput: one word per cycle, set by the fully pipelined divider.
// Registers: APB-style, word i at byte address 4 * i, pready always high; the user
// must write them only while no word is in flight, which the block does not enforce.
// Reset: synchronous; empties the pipeline and loads the default calibration.
`include "joystick_deadzone_calibrate_top_macros.svh"

module joystick_deadzone_calibrate_top #(
   parameter int FULL_SCALE = 127
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [jdc_pkg::DATA_W-1:0]  req_raw_x,
   input  wire logic [jdc_pkg::DATA_W-1:0]  req_raw_y,
   output logic                             rsp_valid,
   output logic signed [jdc_pkg::OUT_W-1:0] rsp_axis_x,
   output logic signed [jdc_pkg::OUT_W-1:0] rsp_axis_y,
   output logic                             rsp_centred,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [4:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import jdc_pkg::*;

   localparam int NW  = $clog2(1023 * FULL_SCALE + 1);
   localparam int NS  = (NW + DIV_BPS - 1) / DIV_BPS;
   localparam int LAT = NS + 3;
   localparam int SBX = $bits(axis_side_type) + 1;
   localparam int SBY = $bits(axis_side_type);

   cfg_type         cfg_ff, cfg_in;
   logic            wr;
   reg_index_type   idx;
   logic            accept;

   logic            p_valid, p_centred;
   logic [NW-1:0]   p_num_x, p_num_y;
   logic [DATA_W-1:0] p_den_x, p_den_y;
   axis_side_type   p_side_x, p_side_y;

   logic            dx_valid, dy_valid;
   logic [NW-1:0]   q_x, q_y;
   logic [SBX-1:0]  sb_x;
   logic [SBY-1:0]  sb_y;
   axis_side_type   d_side_x, d_side_y;
   logic            d_centred;

   // handshake
   assign busy   = reset;
   assign accept = start && !busy;
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;
   assign idx    = reg_index_type'(paddr[4:2]);

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_ENABLE:   cfg_in.enable    = pwdata[0];
            REG_DEADZONE: cfg_in.dz_radius = pwdata[DATA_W-1:0];
            REG_X_MIN:    cfg_in.x_min     = pwdata[DATA_W-1:0];
            REG_X_MID:    cfg_in.x_mid     = pwdata[DATA_W-1:0];
            REG_X_MAX:    cfg_in.x_max     = pwdata[DATA_W-1:0];
            REG_Y_MIN:    cfg_in.y_min     = pwdata[DATA_W-1:0];
            REG_Y_MID:    cfg_in.y_mid     = pwdata[DATA_W-1:0];
            REG_Y_MAX:    cfg_in.y_max     = pwdata[DATA_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= RST_ENABLE;
         cfg_ff.dz_radius <= RST_DEADZONE;
         cfg_ff.x_min     <= RST_MIN;
         cfg_ff.x_mid     <= RST_MID;
         cfg_ff.x_max     <= RST_MAX;
         cfg_ff.y_min     <= RST_MIN;
         cfg_ff.y_mid     <= RST_MID;
         cfg_ff.y_max     <= RST_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read
   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_ENABLE:   prdata = 32'(cfg_ff.enable);
         REG_DEADZONE: prdata = 32'(cfg_ff.dz_radius);
         REG_X_MIN:    prdata = 32'(cfg_ff.x_min);
         REG_X_MID:    prdata = 32'(cfg_ff.x_mid);
         REG_X_MAX:    prdata = 32'(cfg_ff.x_max);
         REG_Y_MIN:    prdata = 32'(cfg_ff.y_min);
         REG_Y_MID:    prdata = 32'(cfg_ff.y_mid);
         REG_Y_MAX:    prdata = 32'(cfg_ff.y_max);
         default:      prdata = '0;
      endcase
   end

   // offsets, deadzone test, numerators and divisor choice
   jdc_prep #(
      .FULL_SCALE (FULL_SCALE),
      .NW         (NW)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .raw_x       (req_raw_x),
      .raw_y       (req_raw_y),
      .cfg         (cfg_ff),
      .out_valid   (p_valid),
      .out_centred (p_centred),
      .num_x       (p_num_x),
      .num_y       (p_num_y),
      .den_x       (p_den_x),
      .den_y       (p_den_y),
      .side_x      (p_side_x),
      .side_y      (p_side_y)
   );

   // one divider per axis, x carries the centred flag
   jdc_div #(
      .NW  (NW),
      .SBW (SBX)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .num       (p_num_x),
      .den       (p_den_x),
      .side_in   ({p_centred, p_side_x}),
      .out_valid (dx_valid),
      .quo       (q_x),
      .side_out  (sb_x)
   );

   jdc_div #(
      .NW  (NW),
      .SBW (SBY)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .num       (p_num_y),
      .den       (p_den_y),
      .side_in   (p_side_y),
      .out_valid (dy_valid),
      .quo       (q_y),
      .side_out  (sb_y)
   );

   assign d_centred = sb_x[SBX-1];
   assign d_side_x  = sb_x[SBY-1:0];
   assign d_side_y  = sb_y;

   // saturate, clamp and register the result
   jdc_post #(
      .FULL_SCALE (FULL_SCALE),
      .NW         (NW)
   ) u_post (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dx_valid),
      .centred     (d_centred),
      .quo_x       (q_x),
      .quo_y       (q_y),
      .side_x      (d_side_x),
      .side_y      (d_side_y),
      .rsp_valid   (rsp_valid),
      .rsp_axis_x  (rsp_axis_x),
      .rsp_axis_y  (rsp_axis_y),
      .rsp_centred (rsp_centred)
   );

   // checks
   `JDC_ASSERT_NOW(a_lanes_aligned, dx_valid || dy_valid, dx_valid && dy_valid, "divider lanes out of step")
   `JDC_ASSERT_NOW(a_latency, accept, ##LAT rsp_valid, "word accepted without a result")
   `JDC_ASSERT_NOW(a_no_extra, rsp_valid, $past(accept, LAT), "result without an accepted word")
   `JDC_ASSERT_NOW(a_centred_zero, rsp_valid && rsp_centred, rsp_axis_x == 0 && rsp_axis_y == 0, "centred result not zero")
   `JDC_ASSERT_NEXT(a_dz_write, wr && idx == REG_DEADZONE, cfg_ff.dz_radius == $past(pwdata[DATA_W-1:0]), "deadzone write lost")

endmodule

`default_nettype wire
